// ----- src/sgns_pkg.sv -----
// Shared types, constants and controller states for the Sobel / non-max suppression unit.
`default_nettype none
package sgns_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int MAG_W          = 21;
  localparam int GRAD_W         = 23;
  localparam int EDGE_W         = 11;

  typedef struct packed {
    logic [7:0] pixel;
    logic       drain;
  } in_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_magnitude;
    logic [1:0]        sector;
    logic              frame_last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_GXY,
    ST_SQUARE,
    ST_GRAD,
    ST_NMS,
    ST_SQRT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic read;
    logic shift;
    logic gxy;
    logic square;
    logic grad;
    logic nms;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic sqrt_busy;
    logic out_free;
  } status_t;

  localparam logic [1:0] SEC_HORIZ = 2'd0;
  localparam logic [1:0] SEC_DIAG  = 2'd1;
  localparam logic [1:0] SEC_VERT  = 2'd2;
  localparam logic [1:0] SEC_ANTI  = 2'd3;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

endpackage
`default_nettype wire

// ----- src/sgns_isqrt.sv -----
// Iterative floor square root, one result bit per cycle.
`default_nettype none
module sgns_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sgns_pkg::MAG_W-1:0] value,
  output logic                           busy,
  output logic [sgns_pkg::EDGE_W-1:0]    root
);
  import sgns_pkg::*;

  logic [MAG_W:0] rem;
  logic [MAG_W:0] res;
  logic [MAG_W:0] bitm;
  logic [MAG_W:0] trial;

  assign trial = res + bitm;
  assign root  = res[EDGE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitm[0]) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, value};
      res  <= '0;
      bitm <= (MAG_W+1)'(1) << (MAG_W - 1);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

endmodule
`default_nettype wire

// ----- src/sgns_datapath.sv -----
// Datapath: position counters, line stores, windows, Sobel, sector, suppression, square root, output register.
`default_nettype none
module sgns_datapath #(
  parameter int MAX_WIDTH  = sgns_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgns_pkg::DEF_MAX_HEIGHT,
  localparam int AW    = $clog2(MAX_WIDTH),
  localparam int COL_W = $clog2(MAX_WIDTH + 1),
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sgns_pkg::cmd_t    cmd,
  output sgns_pkg::status_t      status,
  input  wire logic [COL_W-1:0]  width,
  input  wire logic [ROW_W-1:0]  height,
  input  wire logic              restart,
  input  wire sgns_pkg::in_t     in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sgns_pkg::out_t         out_data
);
  import sgns_pkg::*;

  // stream position
  logic [COL_W-1:0] in_col, out_col;
  logic [ROW_W-1:0] in_row, out_row;
  logic [COL_W-1:0] col_inc, ocol_inc;
  logic             a_emit, a_last, a_sobel, a_grad_rows;
  logic [COL_W-1:0] a_gc;

  // latched item
  logic [7:0]    px;
  logic [AW-1:0] c_q, gc_q;
  logic          sobel_ok, nms_ok, emit, last;

  // line stores
  logic [7:0]        pix_a [MAX_WIDTH];
  logic [7:0]        pix_b [MAX_WIDTH];
  logic [GRAD_W-1:0] grd_a [MAX_WIDTH];
  logic [GRAD_W-1:0] grd_b [MAX_WIDTH];
  logic [7:0]        pa_rd, pb_rd;
  logic [GRAD_W-1:0] ga_rd, gb_rd;

  logic [7:0]        pw [3][3];
  logic [GRAD_W-1:0] gw [3][3];

  // Sobel pipeline
  logic [9:0]  sum_r, sum_l, sum_b, sum_t;
  logic signed [11:0] gx, gy, gxn, gyn;
  logic [9:0]  ay, ax;
  logic        gy_zero, gx_pos;
  logic        s_gy_zero, s_gx_pos, s_dpos;
  logic [19:0] aa, yy, dd;
  logic [21:0] ss;
  logic [10:0] dsum;
  logic signed [11:0] dval;
  logic [21:0] two_aa;
  logic [MAG_W-1:0] mag2;
  logic [1:0]  sec;
  logic [GRAD_W-1:0] g;

  // suppression
  logic [MAG_W-1:0]  m, n1, n2;
  logic [1:0]        csec, sec_q;
  logic              keep;
  logic              sq_busy;
  logic [EDGE_W-1:0] root;

  assign col_inc  = in_col + COL_W'(1);
  assign ocol_inc = out_col + COL_W'(1);
  assign a_emit   = (in_row > ROW_W'(2)) || (in_row == ROW_W'(2) && in_col >= COL_W'(2));
  assign a_last   = a_emit && out_row == height - ROW_W'(1) && out_col == width - COL_W'(1);
  assign a_sobel  = in_col >= COL_W'(2) && in_row >= ROW_W'(2) && in_row <= height - ROW_W'(1);
  assign a_gc     = (in_col != '0) ? in_col - COL_W'(1) : width - COL_W'(1);
  // gradient row is one behind (two when wrapping to the previous row's end)
  assign a_grad_rows = (in_col != '0) ?
                       (in_row >= ROW_W'(3) && in_row <= height) :
                       (in_row >= ROW_W'(4) && in_row <= height + ROW_W'(1));

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cmd.accept) begin
      if (a_last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (col_inc >= width) begin
          in_col <= '0;
          in_row <= in_row + ROW_W'(1);
        end else begin
          in_col <= col_inc;
        end
        if (a_emit) begin
          if (ocol_inc >= width) begin
            out_col <= '0;
            out_row <= out_row + ROW_W'(1);
          end else begin
            out_col <= ocol_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px       <= in_data.drain ? 8'd0 : in_data.pixel;
      c_q      <= in_col[AW-1:0];
      gc_q     <= a_gc[AW-1:0];
      sobel_ok <= a_sobel;
      nms_ok   <= a_grad_rows && (in_col == '0 || in_col >= COL_W'(3));
      emit     <= a_emit;
      last     <= a_last;
    end
  end

  // line store reads, then pixel write-back with the shift and gradient write-back with grad
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      pa_rd <= pix_a[c_q];
      pb_rd <= pix_b[c_q];
      ga_rd <= grd_a[gc_q];
      gb_rd <= grd_b[gc_q];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      pix_a[c_q] <= px;
      pix_b[c_q] <= pa_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      grd_a[gc_q] <= g;
      grd_b[gc_q] <= ga_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pw[i][j] <= '0;
          gw[i][j] <= '0;
        end
      end
    end else begin
      if (cmd.shift) begin
        for (int i = 0; i < 3; i++) begin
          pw[i][0] <= pw[i][1];
          pw[i][1] <= pw[i][2];
        end
        pw[0][2] <= pb_rd;
        pw[1][2] <= pa_rd;
        pw[2][2] <= px;
      end
      if (cmd.grad) begin
        for (int i = 0; i < 3; i++) begin
          gw[i][0] <= gw[i][1];
          gw[i][1] <= gw[i][2];
        end
        gw[0][2] <= gb_rd;
        gw[1][2] <= ga_rd;
        gw[2][2] <= g;
      end
    end
  end

  // gradients, folded so that gy >= 0
  assign sum_r = 10'(pw[0][2]) + {1'b0, pw[1][2], 1'b0} + 10'(pw[2][2]);
  assign sum_l = 10'(pw[0][0]) + {1'b0, pw[1][0], 1'b0} + 10'(pw[2][0]);
  assign sum_b = 10'(pw[2][0]) + {1'b0, pw[2][1], 1'b0} + 10'(pw[2][2]);
  assign sum_t = 10'(pw[0][0]) + {1'b0, pw[0][1], 1'b0} + 10'(pw[0][2]);
  assign gx    = $signed({2'b00, sum_r}) - $signed({2'b00, sum_l});
  assign gy    = $signed({2'b00, sum_b}) - $signed({2'b00, sum_t});
  assign gxn   = gy[11] ? -gx : gx;
  assign gyn   = gy[11] ? -gy : gy;

  always_ff @(posedge clk) begin
    if (cmd.gxy) begin
      ay      <= gyn[9:0];
      ax      <= gxn[11] ? 10'(-gxn) : gxn[9:0];
      gy_zero <= gyn == '0;
      gx_pos  <= !gxn[11] && gxn != '0;
    end
  end

  assign dsum = 11'(ay) + 11'(ax);
  assign dval = $signed({2'b00, ay}) - $signed({2'b00, ax});

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      aa        <= ax * ax;
      yy        <= ay * ay;
      ss        <= dsum * dsum;
      dd        <= dval[9:0] * dval[9:0];
      s_dpos    <= !dval[11] && dval != '0;
      s_gy_zero <= gy_zero;
      s_gx_pos  <= gx_pos;
    end
  end

  assign two_aa = {1'b0, aa, 1'b0};
  assign mag2   = MAG_W'(aa) + MAG_W'(yy);

  always_comb begin
    if (s_gy_zero || ss < two_aa) begin
      sec = SEC_HORIZ;
    end else if (s_dpos && 22'(dd) > two_aa) begin
      sec = SEC_VERT;
    end else begin
      sec = s_gx_pos ? SEC_DIAG : SEC_ANTI;
    end
    g = sobel_ok ? {sec, mag2} : '0;
  end

  // suppression along the sector
  always_comb begin
    m    = gw[1][1][MAG_W-1:0];
    csec = gw[1][1][GRAD_W-1:MAG_W];
    case (csec)
      SEC_HORIZ: begin
        n1 = gw[1][2][MAG_W-1:0];
        n2 = gw[1][0][MAG_W-1:0];
      end
      SEC_DIAG: begin
        n1 = gw[0][2][MAG_W-1:0];
        n2 = gw[2][0][MAG_W-1:0];
      end
      SEC_VERT: begin
        n1 = gw[0][1][MAG_W-1:0];
        n2 = gw[2][1][MAG_W-1:0];
      end
      default: begin
        n1 = gw[0][0][MAG_W-1:0];
        n2 = gw[2][2][MAG_W-1:0];
      end
    endcase
    keep = nms_ok && m >= n1 && m >= n2;
  end

  always_ff @(posedge clk) begin
    if (cmd.nms) begin
      sec_q <= nms_ok ? csec : SEC_HORIZ;
    end
  end

  sgns_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.nms),
    .value (keep ? m : '0),
    .busy  (sq_busy),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data.edge_magnitude <= root;
      out_data.sector         <= sec_q;
      out_data.frame_last     <= last;
    end
  end

  assign status.emit      = emit;
  assign status.sqrt_busy = sq_busy;
  assign status.out_free  = !out_valid || !out_stall;

endmodule
`default_nettype wire

// ----- src/sgns_ctrl.sv -----
// Controller: sequences one request through read and Sobel and, when it emits a result, suppression, root and output.
`default_nettype none
module sgns_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sgns_pkg::status_t  status,
  output sgns_pkg::cmd_t          cmd
);
  import sgns_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_SHIFT;
      ST_SHIFT:  state_next = ST_GXY;
      ST_GXY:    state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_GRAD;
      ST_GRAD:   state_next = status.emit ? ST_NMS : ST_IDLE;
      ST_NMS:    state_next = ST_SQRT;
      ST_SQRT:   if (!status.sqrt_busy) state_next = ST_PUSH;
      ST_PUSH:   if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ:   cmd.read   = 1'b1;
      ST_SHIFT:  cmd.shift  = 1'b1;
      ST_GXY:    cmd.gxy    = 1'b1;
      ST_SQUARE: cmd.square = 1'b1;
      ST_GRAD:   cmd.grad   = 1'b1;
      ST_NMS:    cmd.nms    = 1'b1;
      ST_SQRT:   cmd.push   = 1'b0;
      ST_PUSH:   cmd.push   = status.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/sobel_gradient_nonmax_suppress_unit.sv -----
// Top level of the Sobel gradient and non-maximum suppression unit.
// Grey pixels come in raster order, one request at a time; each request runs
// through line store read, window shift, Sobel sums, squares, and sector and
// line store write. A request that emits a result then goes through
// suppression and an 11-step square root; it waits on that bit-serial root
// and, while the output is stalled, on the output register. A finished
// result sits in the output register, so the next request can be taken
// while it waits. Results trail the input by 2*width+2 requests; send drain
// requests after the frame to push out the tail. The result carrying
// frame_last restarts the frame. Register writes (width at 0x0, height at
// 0x4) also restart the frame and must happen while the unit is idle;
// values are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
// The line stores need no clearing pass: border handling never uses an
// entry that the current frame has not written.
`default_nettype none
module sobel_gradient_nonmax_suppress_unit #(
  parameter int MAX_WIDTH  = sgns_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgns_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sgns_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sgns_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import sgns_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 3);

  logic [10:0]      image_width;
  logic [12:0]      image_height;
  logic             cfg_wr;
  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  cmd_t             cmd;
  status_t          status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 13'd480;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  image_width  <= pwdata[10:0];
        REG_HEIGHT: image_height <= pwdata[12:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {21'd0, image_width};
      REG_HEIGHT: prdata = {19'd0, image_height};
      default:    prdata = '0;
    endcase
  end

  // clamp to the supported frame size
  always_comb begin
    if (image_width < 11'd3) begin
      w_eff = COL_W'(3);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = COL_W'(image_width);
    end
    if (image_height < 13'd3) begin
      h_eff = ROW_W'(3);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(image_height);
    end
  end

  sgns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sgns_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .width     (w_eff),
    .height    (h_eff),
    .restart   (cfg_wr),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- sim/sobel_gradient_nonmax_suppress_unit_tb.sv -----
// Testbench for the Sobel gradient / non-max suppression unit: frame stimulus with prediction.
`default_nettype none
module sobel_gradient_nonmax_suppress_unit_tb;
  import sgns_pkg::*;

  localparam int LINE_MAX   = 1024;
  localparam int HEIGHT_MAX = 4096;
  localparam int IDLE_LIMIT = 4000;  // cycles without any accept before giving up
  localparam int TAIL_WAIT  = 40;    // settling time after the queues run empty

  // pixel pattern kinds for frame content
  typedef enum int {
    PAT_NOISE, PAT_COL_STEP, PAT_ROW_STEP, PAT_DIAG, PAT_ANTI, PAT_RAMP, PAT_CHECKER
  } pattern_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sobel_gradient_nonmax_suppress_unit u_dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Edge predictor: own copy of the line stores, windows and stream position.
  // ---------------------------------------------------------------------------
  logic [10:0] cfg_width  = 11'd640;
  logic [12:0] cfg_height = 13'd480;
  logic [7:0]  pix_line [2*LINE_MAX];
  logic [7:0]  pix_win  [3][3];
  logic [22:0] grad_line[2*LINE_MAX];
  logic [22:0] grad_win [3][3];
  int          in_col, in_row, out_idx;

  in_t  request_q[$];   // requests waiting for the driver
  out_t edge_q[$];      // predicted edge results, oldest first
  int   errors = 0;
  int   sent_count = 0;

  function automatic int eff_width();
    return cfg_width < 3 ? 3 : (cfg_width > LINE_MAX ? LINE_MAX : int'(cfg_width));
  endfunction

  function automatic int eff_height();
    return cfg_height < 3 ? 3 : (cfg_height > HEIGHT_MAX ? HEIGHT_MAX : int'(cfg_height));
  endfunction

  function automatic int floor_sqrt(int v);
    int root;
    root = 0;
    while ((root + 1) * (root + 1) <= v) root++;
    return root;
  endfunction

  // Sobel on the pixel window: packed {sector, squared magnitude}
  function automatic logic [22:0] sobel_grad();
    int gx, gy, ax, d, mag2;
    logic [1:0] sec;
    gx = (pix_win[0][2] + 2*pix_win[1][2] + pix_win[2][2])
       - (pix_win[0][0] + 2*pix_win[1][0] + pix_win[2][0]);
    gy = (pix_win[2][0] + 2*pix_win[2][1] + pix_win[2][2])
       - (pix_win[0][0] + 2*pix_win[0][1] + pix_win[0][2]);
    mag2 = gx*gx + gy*gy;
    // fold into the upper half plane
    if (gy < 0) begin
      gx = -gx;
      gy = -gy;
    end
    ax = gx < 0 ? -gx : gx;
    if (gy == 0 || (gy + ax)*(gy + ax) < 2*ax*ax) begin
      sec = SEC_HORIZ;
    end else begin
      d = gy - ax;
      if (d > 0 && d*d > 2*ax*ax) sec = SEC_VERT;
      else sec = gx > 0 ? SEC_DIAG : SEC_ANTI;
    end
    return {sec, mag2[MAG_W-1:0]};
  endfunction

  task automatic predict_edge(input in_t req);
    int w, h, r, c, gr, gc;
    logic [7:0]  px;
    logic [22:0] g, ctr, n1, n2;
    out_t res;
    w  = eff_width();
    h  = eff_height();
    r  = in_row;
    c  = in_col;
    px = req.drain ? 8'd0 : req.pixel;
    g  = '0;
    if (c >= w) c = w - 1;
    for (int i = 0; i < 3; i++) begin
      pix_win[i][0] = pix_win[i][1];
      pix_win[i][1] = pix_win[i][2];
    end
    pix_win[0][2] = pix_line[LINE_MAX + c];
    pix_win[1][2] = pix_line[c];
    pix_win[2][2] = px;
    pix_line[LINE_MAX + c] = pix_line[c];
    pix_line[c] = px;
    if (c >= 2 && r >= 2 && r <= h - 1) g = sobel_grad();
    // gradient stream runs one row and one column behind, wrapping to the end of the row before that at column 0
    if (c >= 1) begin
      gr = r - 1;
      gc = c - 1;
    end else begin
      gr = r - 2;
      gc = w - 1;
    end
    for (int i = 0; i < 3; i++) begin
      grad_win[i][0] = grad_win[i][1];
      grad_win[i][1] = grad_win[i][2];
    end
    grad_win[0][2] = grad_line[LINE_MAX + gc];
    grad_win[1][2] = grad_line[gc];
    grad_win[2][2] = g;
    grad_line[LINE_MAX + gc] = grad_line[gc];
    grad_line[gc] = g;
    if (r > 2 || (r == 2 && c >= 2)) begin
      res = '0;
      if (gc >= 2 && gr >= 2 && gr <= h - 1) begin
        ctr = grad_win[1][1];
        res.sector = ctr[22:21];
        case (ctr[22:21])
          SEC_HORIZ: begin n1 = grad_win[1][2]; n2 = grad_win[1][0]; end
          SEC_DIAG:  begin n1 = grad_win[0][2]; n2 = grad_win[2][0]; end
          SEC_VERT:  begin n1 = grad_win[0][1]; n2 = grad_win[2][1]; end
          default:   begin n1 = grad_win[0][0]; n2 = grad_win[2][2]; end
        endcase
        if (ctr[20:0] >= n1[20:0] && ctr[20:0] >= n2[20:0])
          res.edge_magnitude = EDGE_W'(floor_sqrt(int'(ctr[20:0])));
      end
      res.frame_last = (out_idx == w*h - 1);
      edge_q.push_back(res);
      if (res.frame_last) begin
        in_col  = 0;
        in_row  = 0;
        out_idx = 0;
        return;
      end
      out_idx = (out_idx + 1) & 32'h7FFFFF;
    end
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
  endtask

  task automatic queue_request(input logic [7:0] pixel, input logic drain);
    in_t req;
    req.pixel = pixel;
    req.drain = drain;
    predict_edge(req);
    request_q.push_back(req);
    sent_count++;
  endtask

  function automatic logic [7:0] pattern_pixel(pattern_t pat, int r, int c,
                                               logic [7:0] lo, logic [7:0] hi, int thr);
    case (pat)
      PAT_NOISE:    return 8'($urandom);
      PAT_COL_STEP: return c < thr ? hi : lo;
      PAT_ROW_STEP: return r < thr ? hi : lo;
      PAT_DIAG:     return (r + c) < thr ? hi : lo;
      PAT_ANTI:     return (c - r + 8) < thr ? hi : lo;
      PAT_RAMP:     return 8'(lo + r*hi + c*thr);
      default:      return ((r + c) & 1) ? hi : lo;
    endcase
  endfunction

  // One whole frame plus the drain tail that pushes out its last result.
  task automatic queue_frame(input pattern_t pat, input logic [7:0] lo, input logic [7:0] hi,
                             input int thr);
    int w, h;
    w = eff_width();
    h = eff_height();
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if ($urandom_range(0, 29) == 0) queue_request(8'($urandom), 1'b1);
        else queue_request(pattern_pixel(pat, r, c, lo, hi, thr), 1'b0);
    // past the frame a plain pixel acts like a drain
    for (int k = 0; k < 2*w + 2; k++)
      queue_request(8'($urandom), $urandom_range(0, 3) != 0);
  endtask

  task automatic queue_random_frame();
    pattern_t pat;
    logic [7:0] lo, hi;
    pat = pattern_t'($urandom_range(0, 6));
    lo  = $urandom_range(0, 3) == 0 ? 8'd0   : 8'($urandom);
    hi  = $urandom_range(0, 3) == 0 ? 8'd255 : 8'($urandom);
    queue_frame(pat, lo, hi, $urandom_range(0, 14));
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || edge_q.size() != 0 || in_valid) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  // two-phase write; also restarts the predicted frame
  task automatic reg_write(input logic [0:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = value[10:0];
    else cfg_height = value[12:0];
    in_col  = 0;
    in_row  = 0;
    out_idx = 0;
  endtask

  task automatic set_size(input int w, input int h);
    wait_idle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length with random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) void'(request_q.pop_front());
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0 && !(in_valid && request_q.size() == 0)) begin
        in_valid <= 1'b1;
        in_data  <= request_q[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor with its own stall pattern.
  // ---------------------------------------------------------------------------
  int stall_style = 0;
  int style_left  = 0;
  int stall_run   = 0;

  task automatic report_mismatch(input string what);
    $display("edge mismatch @%0t: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (edge_q.size() == 0) begin
          report_mismatch("result with nothing predicted");
        end else begin
          want = edge_q.pop_front();
          if (out_data.edge_magnitude != want.edge_magnitude)
            report_mismatch($sformatf("edge_magnitude %0d, predicted %0d",
                                      out_data.edge_magnitude, want.edge_magnitude));
          if (out_data.sector != want.sector)
            report_mismatch($sformatf("sector %0d, predicted %0d",
                                      out_data.sector, want.sector));
          if (out_data.frame_last != want.frame_last)
            report_mismatch($sformatf("frame_last %0b, predicted %0b",
                                      out_data.frame_last, want.frame_last));
        end
      end
      if (style_left <= 0) begin
        stall_style = $urandom_range(0, 2);
        style_left  = $urandom_range(20, 200);
      end
      style_left--;
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 2) == 0;
        default: begin
          if (stall_run <= 0) stall_run = $urandom_range(1, 12);
          stall_run--;
          out_stall <= stall_run > 6;
        end
      endcase
    end
  end

  // watchdog on cycles with no accept on either channel
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sobel_gradient_nonmax_suppress_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < 2*LINE_MAX; i++) begin
      pix_line[i]  = '0;
      grad_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        pix_win[i][j]  = '0;
        grad_win[i][j] = '0;
      end
    in_col  = 0;
    in_row  = 0;
    out_idx = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: smallest frame, full-scale checker and a falling column step (180 deg)
    set_size(3, 3);
    queue_frame(PAT_CHECKER, 8'd0, 8'd255, 0);
    queue_frame(PAT_COL_STEP, 8'd0, 8'd255, 2);

    // random frames at small sizes, now and then out of range (clamped to 3)
    while (sent_count < 1100) begin
      set_size($urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 12),
               $urandom_range(0, 5) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8));
      repeat ($urandom_range(1, 2)) queue_random_frame();
    end

    // widest line, clamped from the top of the field: partial frame, abandoned
    set_size(2047, 1);
    repeat (50) queue_request(8'($urandom), 1'b0);
    // largest heights: partial frames, abandoned by the next write
    set_size(3, 4096);
    repeat (60) queue_request(8'($urandom), 1'b0);
    set_size(1024, 8191);
    repeat (40) queue_request(8'($urandom), $urandom_range(0, 7) == 0);
    set_size(5, 4);
    queue_random_frame();

    wait_idle();
    if (errors == 0) begin
      $display("sobel_gradient_nonmax_suppress_unit regression: pass");
    end else begin
      $display("sobel_gradient_nonmax_suppress_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/sgns_pkg.sv
src/sgns_isqrt.sv
src/sgns_datapath.sv
src/sgns_ctrl.sv
src/sobel_gradient_nonmax_suppress_unit.sv
sim/sobel_gradient_nonmax_suppress_unit_tb.sv
